@@ rtl/core/ffa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned IdW       = 20;
  localparam int unsigned CountW    = $clog2(MaxBlocks + 1);
  localparam int unsigned RipW      = $clog2(MaxBlocks);

  localparam logic [AddrW-1:0] MemSizeReset = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_RIPPLE,
    OP_EVICT,
    OP_INSERT
  } cell_op_e;

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] len;
    logic [IdW-1:0]   owner;
  } entry_t;

  typedef struct packed {
    cell_op_e         op;
    logic             evict;
    logic [AddrW-1:0] size;
    logic [AddrW-1:0] mem_size;
    logic [IdW-1:0]   oldest;
    logic [IdW-1:0]   new_id;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/ffa_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ffa_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ffa_pkg::cell_ctrl_t      ctrl_i,
  input  wire ffa_pkg::entry_t          lo_entry_i,
  input  wire logic                     lo_flag_i,
  input  wire logic [ffa_pkg::AddrW-1:0] lo_addr_i,
  input  wire ffa_pkg::entry_t          up_entry_i,
  output ffa_pkg::entry_t               entry_o,
  output logic                          flag_o,
  output logic [ffa_pkg::AddrW-1:0]     addr_o
);

  logic                      valid_q, valid_d;
  logic [ffa_pkg::AddrW-1:0] start_q, start_d;
  logic [ffa_pkg::AddrW-1:0] len_q, len_d;
  logic [ffa_pkg::IdW-1:0]   owner_q, owner_d;
  logic                      flag_q, flag_d;
  logic [ffa_pkg::AddrW-1:0] addr_q, addr_d;
  logic [ffa_pkg::AddrW:0]   lo_end;
  logic [ffa_pkg::AddrW+1:0] need;

  assign lo_end = {1'b0, lo_entry_i.start} + {1'b0, lo_entry_i.len};
  assign need   = {1'b0, lo_end} + {2'b00, ctrl_i.size};

  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    len_d   = len_q;
    owner_d = owner_q;
    flag_d  = flag_q;
    addr_d  = addr_q;
    unique case (ctrl_i.op)
      ffa_pkg::OP_LOAD: begin
        addr_d = lo_end[ffa_pkg::AddrW-1:0];
        if (ctrl_i.evict) begin
          flag_d = valid_q && (owner_q == ctrl_i.oldest);
        end else if (valid_q) begin
          flag_d = ({2'b00, start_q} >= need);
        end else begin
          flag_d = lo_entry_i.valid && ({2'b00, ctrl_i.mem_size} >= need);
        end
      end
      ffa_pkg::OP_RIPPLE: begin
        flag_d = flag_q | lo_flag_i;
        if (lo_flag_i) begin
          addr_d = lo_addr_i;
        end
      end
      ffa_pkg::OP_EVICT: begin
        if (flag_q) begin
          valid_d = up_entry_i.valid;
          start_d = up_entry_i.start;
          len_d   = up_entry_i.len;
          owner_d = up_entry_i.owner;
        end
      end
      ffa_pkg::OP_INSERT: begin
        if (flag_q && lo_flag_i) begin
          valid_d = lo_entry_i.valid;
          start_d = lo_entry_i.start;
          len_d   = lo_entry_i.len;
          owner_d = lo_entry_i.owner;
        end else if (flag_q) begin
          valid_d = 1'b1;
          start_d = addr_q;
          len_d   = ctrl_i.size;
          owner_d = ctrl_i.new_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      flag_q  <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
    owner_q <= owner_d;
    addr_q  <= addr_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.start = start_q;
  assign entry_o.len   = len_q;
  assign entry_o.owner = owner_q;
  assign flag_o        = flag_q;
  assign addr_o        = addr_q;

endmodule

`default_nettype wire

@@ rtl/core/first_fit_allocator_fifo_evict.sv @@
`timescale 1ns / 1ps
`default_nettype none

// First-fit allocator with oldest-first eviction over a row of 256 cells kept
// in address order. Every table pass (a gap search or an eviction) loads and
// evaluates each cell, lets the first-match flag ripple from cell to cell, and
// then shifts the row. A request runs one search when it fits, an eviction
// first when the table is full, and a further eviction and search for every
// search that fails; refused requests skip the passes. One request is
// worked on at a time; a new one is taken while the previous result waits,
// and a finished request stalls until the output register is free.
module first_fit_allocator_fifo_evict (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] request_size_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [19:0]      request_id_o,
  output logic [15:0]      start_address_o,
  output logic [19:0]      oldest_live_id_o,
  output logic             error_o
);

  localparam int unsigned N = ffa_pkg::MaxBlocks;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_RIPPLE = 5'b00100,
    S_ACT    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [ffa_pkg::AddrW-1:0]   mem_q;
  logic [ffa_pkg::AddrW-1:0]   size_q, size_d;
  logic                        evict_q, evict_d;
  logic [ffa_pkg::RipW-1:0]    cnt_q, cnt_d;
  logic [ffa_pkg::CountW-1:0]  count_q, count_d;
  logic [ffa_pkg::IdW-1:0]     next_id_q, next_id_d;
  logic [ffa_pkg::IdW-1:0]     oldest_q, oldest_d;
  logic [ffa_pkg::IdW-1:0]     res_id_q, res_id_d;
  logic [ffa_pkg::AddrW-1:0]   res_addr_q, res_addr_d;
  logic                        res_err_q, res_err_d;
  logic                        out_valid_q;
  logic [19:0]                 out_id_q;
  logic [15:0]                 out_addr_q;
  logic [19:0]                 out_oldest_q;
  logic                        out_err_q;
  logic                        out_free;
  logic                        found;

  ffa_pkg::cell_ctrl_t         ctrl;
  ffa_pkg::entry_t             entries [N];
  logic [N-1:0]                flags;
  logic [N-1:0]                valids;
  logic [ffa_pkg::AddrW-1:0]   addrs [N];

  ffa_pkg::entry_t             floor_entry;
  ffa_pkg::entry_t             ceil_entry;

  assign floor_entry = '{valid: 1'b1, start: '0, len: '0, owner: '0};
  assign ceil_entry  = '{valid: 1'b0, start: '0, len: '0, owner: '0};

  for (genvar i = 0; i < N; i++) begin : g_cell
    ffa_pkg::entry_t           lo_e;
    ffa_pkg::entry_t           up_e;
    logic                      lo_f;
    logic [ffa_pkg::AddrW-1:0] lo_a;
    if (i == 0) begin : g_first
      assign lo_e = floor_entry;
      assign lo_f = 1'b0;
      assign lo_a = '0;
    end else begin : g_mid
      assign lo_e = entries[i-1];
      assign lo_f = flags[i-1];
      assign lo_a = addrs[i-1];
    end
    if (i == N - 1) begin : g_last
      assign up_e = ceil_entry;
    end else begin : g_below
      assign up_e = entries[i+1];
    end
    ffa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .lo_entry_i (lo_e),
      .lo_flag_i  (lo_f),
      .lo_addr_i  (lo_a),
      .up_entry_i (up_e),
      .entry_o    (entries[i]),
      .flag_o     (flags[i]),
      .addr_o     (addrs[i])
    );
    assign valids[i] = entries[i].valid;
  end

  assign found    = flags[N-1];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ctrl.evict    = evict_q;
    ctrl.size     = size_q;
    ctrl.mem_size = mem_q;
    ctrl.oldest   = oldest_q;
    ctrl.new_id   = next_id_q;
    unique case (state_q)
      S_LOAD:   ctrl.op = ffa_pkg::OP_LOAD;
      S_RIPPLE: ctrl.op = ffa_pkg::OP_RIPPLE;
      S_ACT: begin
        if (evict_q) begin
          ctrl.op = ffa_pkg::OP_EVICT;
        end else if (found) begin
          ctrl.op = ffa_pkg::OP_INSERT;
        end else begin
          ctrl.op = ffa_pkg::OP_HOLD;
        end
      end
      default:  ctrl.op = ffa_pkg::OP_HOLD;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    size_d     = size_q;
    evict_d    = evict_q;
    cnt_d      = cnt_q;
    count_d    = count_q;
    next_id_d  = next_id_q;
    oldest_d   = oldest_q;
    res_id_d   = res_id_q;
    res_addr_d = res_addr_q;
    res_err_d  = res_err_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          size_d = request_size_i;
          if ((request_size_i == '0) || (request_size_i > mem_q) || (next_id_q == '0)) begin
            res_id_d   = '0;
            res_addr_d = '0;
            res_err_d  = 1'b1;
            state_d    = S_DONE;
          end else begin
            evict_d = (count_q == ffa_pkg::CountW'(N));
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cnt_d   = '0;
        state_d = S_RIPPLE;
      end
      S_RIPPLE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ffa_pkg::RipW'(N - 2)) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        if (evict_q) begin
          count_d = count_q - 1'b1;
          if (count_q == ffa_pkg::CountW'(1)) begin
            oldest_d = next_id_q;
          end else begin
            oldest_d = oldest_q + 1'b1;
          end
          evict_d = 1'b0;
          state_d = S_LOAD;
        end else if (found) begin
          count_d = count_q + 1'b1;
          if (count_q == '0) begin
            oldest_d = next_id_q;
          end
          res_id_d   = next_id_q;
          res_addr_d = addrs[N-1];
          res_err_d  = 1'b0;
          next_id_d  = next_id_q + 1'b1;
          state_d    = S_DONE;
        end else begin
          evict_d = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mem_q       <= ffa_pkg::MemSizeReset;
      evict_q     <= 1'b0;
      cnt_q       <= '0;
      count_q     <= '0;
      next_id_q   <= ffa_pkg::IdW'(1);
      oldest_q    <= ffa_pkg::IdW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      evict_q   <= evict_d;
      cnt_q     <= cnt_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      oldest_q  <= oldest_d;
      if (cfg_we_i) begin
        mem_q <= cfg_data_i;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    res_id_q   <= res_id_d;
    res_addr_q <= res_addr_d;
    res_err_q  <= res_err_d;
    if ((state_q == S_DONE) && out_free) begin
      out_id_q     <= res_id_q;
      out_addr_q   <= res_addr_q;
      out_oldest_q <= oldest_q;
      out_err_q    <= res_err_q;
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign request_id_o     = out_id_q;
  assign start_address_o  = out_addr_q;
  assign oldest_live_id_o = out_oldest_q;
  assign error_o          = out_err_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ffa_pkg::CountW'(N))
    else $error("live count above table depth");

  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valids) == int'(count_q))
    else $error("cell valid bits disagree with live count");

  a_empty_always_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACT) && !evict_q && (count_q == '0) |-> found)
    else $error("search on empty table found no gap");

  a_insert_advances_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACT) && !evict_q && found |=> next_id_q == $past(next_id_q) + 1'b1)
    else $error("request id not advanced on insert");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned StallLimit = 400000;

  typedef struct packed {
    logic [ffa_pkg::IdW-1:0]   id;
    logic [ffa_pkg::AddrW-1:0] addr;
    logic [ffa_pkg::IdW-1:0]   oldest;
    logic                      err;
  } alloc_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [15:0]      cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [15:0]      request_size_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [19:0]      request_id_o;
  logic [15:0]      start_address_o;
  logic [19:0]      oldest_live_id_o;
  logic             error_o;

  first_fit_allocator_fifo_evict u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .request_size_i  (request_size_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .request_id_o    (request_id_o),
    .start_address_o (start_address_o),
    .oldest_live_id_o(oldest_live_id_o),
    .error_o         (error_o)
  );

  // allocator shadow state
  longint unsigned  blk_start[ffa_pkg::MaxBlocks];
  longint unsigned  blk_len[ffa_pkg::MaxBlocks];
  int unsigned      blk_owner[ffa_pkg::MaxBlocks];
  int unsigned      live_cnt;
  int unsigned      next_id;
  int unsigned      oldest_id;
  longint unsigned  mem_units;

  alloc_result_t    pending_grants[$];
  int unsigned      error_count = 0;
  int unsigned      stall_cycles = 0;
  bit               idle_on = 1'b1;
  int unsigned      recv_hold = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void evict_oldest_alloc();
    int unsigned pick;
    int unsigned low;
    if (live_cnt == 0) begin
      oldest_id = next_id;
      return;
    end
    pick = 0;
    low = blk_owner[0];
    for (int unsigned i = 1; i < live_cnt; i++) begin
      if (blk_owner[i] < low) begin
        low = blk_owner[i];
        pick = i;
      end
    end
    for (int unsigned i = pick; i + 1 < live_cnt; i++) begin
      blk_start[i] = blk_start[i+1];
      blk_len[i] = blk_len[i+1];
      blk_owner[i] = blk_owner[i+1];
    end
    live_cnt--;
    oldest_id = (low + 1) & 32'hFFFFF;
    if (live_cnt == 0) oldest_id = next_id;
  endfunction

  function automatic int first_fit(longint unsigned size, output longint unsigned addr);
    longint unsigned prev_end;
    prev_end = 0;
    addr = 0;
    for (int unsigned i = 0; i < live_cnt; i++) begin
      if (blk_start[i] >= prev_end && blk_start[i] - prev_end >= size) begin
        addr = prev_end;
        return int'(i);
      end
      prev_end = blk_start[i] + blk_len[i];
    end
    if (mem_units >= prev_end && mem_units - prev_end >= size) begin
      addr = prev_end;
      return int'(live_cnt);
    end
    return -1;
  endfunction

  function automatic alloc_result_t place_request(logic [15:0] size_in);
    alloc_result_t   r;
    longint unsigned size;
    longint unsigned addr;
    int              slot;
    size = size_in;
    addr = 0;
    slot = -1;
    r.id = '0;
    r.addr = '0;
    r.oldest = oldest_id[ffa_pkg::IdW-1:0];
    r.err = 1'b1;
    if (size == 0 || size > mem_units || next_id == 0) return r;
    if (live_cnt >= ffa_pkg::MaxBlocks) evict_oldest_alloc();
    for (int unsigned t = 0; t <= ffa_pkg::MaxBlocks + 1; t++) begin
      slot = first_fit(size, addr);
      if (slot >= 0 || live_cnt == 0) break;
      evict_oldest_alloc();
    end
    if (slot < 0 || live_cnt >= ffa_pkg::MaxBlocks) return r;
    for (int unsigned i = live_cnt; i > slot; i--) begin
      blk_start[i] = blk_start[i-1];
      blk_len[i] = blk_len[i-1];
      blk_owner[i] = blk_owner[i-1];
    end
    blk_start[slot] = addr;
    blk_len[slot] = size;
    blk_owner[slot] = next_id;
    live_cnt++;
    if (live_cnt == 1) oldest_id = next_id;
    r.id = next_id[ffa_pkg::IdW-1:0];
    r.addr = addr[ffa_pkg::AddrW-1:0];
    next_id = (next_id + 1) & 32'hFFFFF;
    r.oldest = oldest_id[ffa_pkg::IdW-1:0];
    r.err = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected result id", request_id_o, 0);
      end else begin
        want = pending_grants.pop_front();
        if (request_id_o !== want.id) report_mismatch("request_id", request_id_o, want.id);
        if (start_address_o !== want.addr)
          report_mismatch("start_address", start_address_o, want.addr);
        if (oldest_live_id_o !== want.oldest)
          report_mismatch("oldest_live_id", oldest_live_id_o, want.oldest);
        if (error_o !== want.err) report_mismatch("error", error_o, want.err);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("first_fit_allocator_fifo_evict test failed");
        $finish;
      end
    end
  end

  // receiver ready with random stall bursts and long hold-offs
  initial begin
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (recv_hold > 0) begin
        out_ready_i = 1'b0;
        recv_hold--;
      end else if (burst > 0) begin
        out_ready_i = 1'b0;
        burst--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;
        burst = $urandom_range(0, 14);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_request(logic [15:0] size);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    request_size_i = size;
    do @(posedge clk_i); while (!in_ready_o);
    pending_grants = {pending_grants, place_request(size)};
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_mem_size(logic [15:0] units);
    drain();
    cfg_we_i = 1'b1;
    cfg_data_i = units;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mem_units = units;
  endtask

  task automatic test_directed();
    send_request(16'd0);
    send_request(16'd1);
    send_request(16'hAAAA);
    send_request(16'h5555);
    send_request(16'hFFFF);
    send_request(16'd2);
    send_request(16'hFFFE);
    send_request(16'd1);
    write_mem_size(16'd1);
    send_request(16'd1);
    send_request(16'd2);
    send_request(16'd1);
    send_request(16'hFFFF);
    write_mem_size(16'd100);
    for (int i = 0; i < 6; i++) send_request(16'd15);
    write_mem_size(16'd40);
    send_request(16'd10);
    send_request(16'd40);
    send_request(16'd41);
    write_mem_size(16'hFFFF);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 270; i++) send_request(16'($urandom_range(1, 3)));
    send_request(16'd200);
  endtask

  task automatic test_backpressure();
    drain();
    recv_hold = 3000;
    for (int i = 0; i < 12; i++) send_request(16'($urandom_range(1, 500)));
  endtask

  task automatic test_random();
    logic [15:0] mem;
    logic [15:0] size;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: mem = 16'hFFFF;
        1: mem = 16'd1;
        2: mem = 16'($urandom_range(2, 300));
        3: mem = 16'($urandom_range(1000, 65535));
        4: mem = 16'($urandom_range(1, 65535));
        default: begin
          mem = 16'hFFFF;
          idle_on = 1'b0;
        end
      endcase
      write_mem_size(mem);
      for (int i = 0; i < 150; i++) begin
        case ($urandom_range(0, 19))
          0: size = 16'($urandom);
          1: size = 16'd0;
          2: size = mem;
          default: size = 16'($urandom_range(1, (mem > 8) ? mem / 8 : 1));
        endcase
        send_request(size);
      end
    end
  endtask

  initial begin
    mem_units = ffa_pkg::MemSizeReset;
    live_cnt = 0;
    next_id = 1;
    oldest_id = 1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("first_fit_allocator_fifo_evict test passed");
    end else begin
      $display("first_fit_allocator_fifo_evict test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ffa_pkg.sv
rtl/core/ffa_cell.sv
rtl/core/first_fit_allocator_fifo_evict.sv
test/tb.sv
